// ----- rtl/bolen_pkg.sv -----
// Shared types and constants for the bounded ordered list engine.
package bolen_pkg;

   localparam int CAPACITY = 16;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int LEN_W    = 5;
   localparam int POS_W    = 8;
   localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   typedef enum logic [2:0] {
      OP_APPEND     = 3'd0,
      OP_PREPEND    = 3'd1,
      OP_INSERT_AT  = 3'd2,
      OP_REMOVE_END = 3'd3,
      OP_REMOVE_TOP = 3'd4,
      OP_REMOVE_AT  = 3'd5,
      OP_LIST       = 3'd6,
      OP_REVERSE    = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]       opcode;
      logic [15:0]      entry_value;
      logic [1:0]       entry_code;
      logic [POS_W-1:0] position;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [15:0]      out_value;
      logic [1:0]       out_code;
      logic             last;
      logic [LEN_W-1:0] length;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  code;
      logic [15:0] value;
   } entry_type;

endpackage

// ----- rtl/bolen_ram.sv -----
// Generic RAM with one write port and two registered read ports.
module bolen_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ----- rtl/bounded_ordered_list_engine.sv -----
// A status result comes after the entry moves or pair swaps that the request needs (each
// move or swap runs through the single RAM write port), after the final write of an insert
// and the second write of each swap; errors answer without touching the RAM.
// Listing gives the entries in order from entry 0, each read first. A new request is taken
// at the edge that takes the last result. Synchronous active-high reset empties the list;
// the entry RAM is not cleared, since only entries below the count are ever read.
module bounded_ordered_list_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bolen_pkg::req_type req_data,
   output logic              rsp_strobe,
   output bolen_pkg::rsp_type rsp_data
);
   import bolen_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE     = 12'h001,
      S_UP_RD    = 12'h002,
      S_UP_WR    = 12'h004,
      S_PUT      = 12'h008,
      S_DN_RD    = 12'h010,
      S_DN_WR    = 12'h020,
      S_SWAP_RD  = 12'h040,
      S_SWAP_LO  = 12'h080,
      S_SWAP_HI  = 12'h100,
      S_LIST_RD  = 12'h200,
      S_LIST_OUT = 12'h400,
      S_RESP     = 12'h800
   } state_type;

   state_type  state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] end_ff, end_in;
   entry_type  new_ff, new_in;
   entry_type  hold_ff, hold_in;
   status_type status_ff, status_in;
   logic       rsp_strobe_ff, rsp_strobe_in;
   rsp_type    rsp_ff, rsp_in;

   logic             wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
   entry_type        wr_data, rd_data_a, rd_data_b;

   logic [CMP_W-1:0] pos_ext, count_ext;
   logic [CNT_W-1:0] pos_idx, ptr_inc, ptr_dec;
   logic             full, empty;
   op_type           op;

   bolen_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr_a(rd_addr_a),
      .rd_data_a(rd_data_a),
      .rd_addr_b(rd_addr_b),
      .rd_data_b(rd_data_b)
   );

   assign op        = op_type'(req_data.opcode);
   assign pos_ext   = CMP_W'(req_data.position);
   assign count_ext = CMP_W'(count_ff);
   assign pos_idx   = CNT_W'(pos_ext - CMP_W'(1));
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign ptr_inc   = ptr_ff + CNT_W'(1);
   assign ptr_dec   = ptr_ff - CNT_W'(1);

   // RAM port steering: port A follows the walking pointer, port B the far end.
   always_comb begin
      rd_addr_a = ptr_ff[ADDR_W-1:0];
      rd_addr_b = end_ff[ADDR_W-1:0];
      wr_en     = 1'b0;
      wr_addr   = ptr_ff[ADDR_W-1:0];
      wr_data   = rd_data_a;
      unique case (state_ff) inside
         S_UP_RD: rd_addr_a = ptr_dec[ADDR_W-1:0];
         S_DN_RD: rd_addr_a = ptr_inc[ADDR_W-1:0];
         S_UP_WR, S_DN_WR: wr_en = 1'b1;
         S_PUT: begin
            wr_en   = 1'b1;
            wr_addr = end_ff[ADDR_W-1:0];
            wr_data = new_ff;
         end
         S_SWAP_LO: begin
            wr_en   = 1'b1;
            wr_data = rd_data_b;
         end
         S_SWAP_HI: begin
            wr_en   = 1'b1;
            wr_addr = end_ff[ADDR_W-1:0];
            wr_data = hold_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      end_in        = end_ff;
      new_in        = new_ff;
      hold_in       = hold_ff;
      status_in     = status_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               new_in.code  = req_data.entry_code;
               new_in.value = req_data.entry_value;
               status_in    = ST_OK;
               state_in     = S_RESP;
               unique case (op) inside
                  OP_APPEND, OP_PREPEND, OP_INSERT_AT: begin
                     if (op == OP_INSERT_AT &&
                         (pos_ext == '0 || pos_ext > count_ext + CMP_W'(1))) begin
                        status_in = ST_RANGE;
                     end else if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                        ptr_in   = count_ff;
                        end_in   = (op == OP_APPEND)  ? count_ff :
                                   (op == OP_PREPEND) ? '0 : pos_idx;
                        state_in = (ptr_in == end_in) ? S_PUT : S_UP_RD;
                     end
                  end
                  OP_REMOVE_END, OP_REMOVE_TOP, OP_REMOVE_AT: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else if (op == OP_REMOVE_AT &&
                                  (pos_ext == '0 || pos_ext > count_ext)) begin
                        status_in = ST_RANGE;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                        end_in   = count_ff - CNT_W'(1);
                        ptr_in   = (op == OP_REMOVE_END) ? end_in :
                                   (op == OP_REMOVE_TOP) ? '0 : pos_idx;
                        state_in = (ptr_in == end_in) ? S_RESP : S_DN_RD;
                     end
                  end
                  OP_LIST: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        ptr_in   = '0;
                        state_in = S_LIST_RD;
                     end
                  end
                  OP_REVERSE: begin
                     ptr_in = '0;
                     end_in = count_ff - CNT_W'(1);
                     if (count_ff > CNT_W'(1)) begin
                        state_in = S_SWAP_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_UP_RD: state_in = S_UP_WR;
         S_UP_WR: begin
            ptr_in   = ptr_dec;
            state_in = (ptr_dec == end_ff) ? S_PUT : S_UP_RD;
         end
         S_PUT: state_in = S_RESP;
         S_DN_RD: state_in = S_DN_WR;
         S_DN_WR: begin
            ptr_in   = ptr_inc;
            state_in = (ptr_inc == end_ff) ? S_RESP : S_DN_RD;
         end
         S_SWAP_RD: state_in = S_SWAP_LO;
         S_SWAP_LO: begin
            // The low write changes what port A would read, so keep its entry.
            hold_in  = rd_data_a;
            state_in = S_SWAP_HI;
         end
         S_SWAP_HI: begin
            ptr_in   = ptr_inc;
            end_in   = end_ff - CNT_W'(1);
            state_in = (ptr_inc + CNT_W'(1) < end_ff) ? S_SWAP_RD : S_RESP;
         end
         S_LIST_RD: state_in = S_LIST_OUT;
         S_LIST_OUT: begin
            rsp_strobe_in    = 1'b1;
            rsp_in.status    = ST_OK;
            rsp_in.out_value = rd_data_a.value;
            rsp_in.out_code  = rd_data_a.code;
            rsp_in.last      = (ptr_inc == count_ff);
            rsp_in.length    = LEN_W'(count_ff);
            ptr_in           = ptr_inc;
            state_in         = (ptr_inc == count_ff) ? S_IDLE : S_LIST_RD;
         end
         S_RESP: begin
            rsp_strobe_in    = 1'b1;
            rsp_in.status    = status_ff;
            rsp_in.out_value = '0;
            rsp_in.out_code  = '0;
            rsp_in.last      = 1'b1;
            rsp_in.length    = LEN_W'(count_ff);
            state_in         = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      end_ff    <= end_in;
      new_ff    <= new_in;
      hold_ff   <= hold_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- rtl/bolen_checker.sv -----
// Port-level checks for the bounded ordered list engine, bound to the top level.
module bolen_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input bolen_pkg::req_type req_data,
   input logic              rsp_strobe,
   input bolen_pkg::rsp_type rsp_data
);
   import bolen_pkg::*;

   // An accepted request always makes the engine busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   // While a listing is still running, the engine must stay busy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |-> busy)
      else $error("list result without busy");

   // Listing results are evenly spaced, with a gap between each result and the next.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |=> !rsp_strobe ##1 rsp_strobe)
      else $error("listing results not evenly spaced");

   // Error results carry no entry and close the request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != ST_OK |->
         rsp_data.last && rsp_data.out_value == '0 && rsp_data.out_code == '0)
      else $error("error result carries entry data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.length <= LEN_W'(CAPACITY))
      else $error("reported length exceeds capacity");

endmodule

bind bounded_ordered_list_engine bolen_checker u_checker (.*);
